[design/md5_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and lookup functions of the MD5 digest unit: the
// round constants, the rotation and message word schedules, the initial
// chaining values and the control store of the step sequencer.
// ----------------------------------------------------------------------------
package md5_pkg;

  // Block buffer geometry: sixteen 32-bit little-endian words.
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned BLOCK_WORDS  = 16;
  localparam int unsigned BLOCK_ADDR_W = $clog2(BLOCK_WORDS);
  localparam int unsigned BYTE_CNT_W   = 6;
  localparam int unsigned ROUND_W      = 6;
  localparam int unsigned WPTR_W       = BLOCK_ADDR_W + 1;
  localparam int unsigned MSG_BITS_W   = 64;

  // Word positions of the length field and the end of the zero fill.
  localparam logic [BLOCK_ADDR_W-1:0] WORD_LEN_LO = BLOCK_ADDR_W'(14);
  localparam logic [BLOCK_ADDR_W-1:0] WORD_LEN_HI = BLOCK_ADDR_W'(15);
  localparam logic [WPTR_W-1:0]       WPTR_FILL   = WPTR_W'(14);
  localparam logic [WPTR_W-1:0]       WPTR_WRAP   = WPTR_W'(16);
  localparam logic [BYTE_CNT_W-1:0]   BYTE_LAST   = BYTE_CNT_W'(63);
  localparam logic [ROUND_W-1:0]      ROUND_LAST  = ROUND_W'(63);

  localparam logic [7:0]        PAD_BYTE  = 8'h80;
  localparam logic [WORD_W-1:0] IV_A      = 32'h67452301;
  localparam logic [WORD_W-1:0] IV_B      = 32'hefcdab89;
  localparam logic [WORD_W-1:0] IV_C      = 32'h98badcfe;
  localparam logic [WORD_W-1:0] IV_D      = 32'h10325476;

  // Four working or chaining words.
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } md5_state_t;

  localparam md5_state_t IV_STATE = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_ACCEPT = 4'd1,
    OP_LOAD   = 4'd2,
    OP_ROUND  = 4'd3,
    OP_ADD    = 4'd4,
    OP_PAD    = 4'd5,
    OP_ZERO   = 4'd6,
    OP_WRAP   = 4'd7,
    OP_LEN_LO = 4'd8,
    OP_LEN_HI = 4'd9,
    OP_EMIT   = 4'd10
  } op_e;

  // Jump conditions: when true the sequencer takes the jump step.
  typedef enum logic [3:0] {
    CND_ALWAYS     = 4'd0,
    CND_NO_WORK    = 4'd1,
    CND_FULL       = 4'd2,
    CND_ROUND_MORE = 4'd3,
    CND_FINAL      = 4'd4,
    CND_LAST       = 4'd5,
    CND_ZERO_MORE  = 4'd6,
    CND_WPTR_END   = 4'd7,
    CND_OUT_BUSY   = 4'd8
  } cond_e;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_DISPATCH = 4'd1;
  localparam step_t STEP_LOAD     = 4'd2;
  localparam step_t STEP_ROUND    = 4'd3;
  localparam step_t STEP_ADD      = 4'd4;
  localparam step_t STEP_CHECK    = 4'd5;
  localparam step_t STEP_PAD      = 4'd6;
  localparam step_t STEP_ZERO     = 4'd7;
  localparam step_t STEP_WRAP     = 4'd8;
  localparam step_t STEP_LEN_LO   = 4'd9;
  localparam step_t STEP_LEN_HI   = 4'd10;
  localparam step_t STEP_EMIT     = 4'd11;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t jump_step;
    step_t next_step;
  } ctrl_word_t;

  // Control store of the sequencer, one word per step.
  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, cond: CND_ALWAYS, jump_step: STEP_IDLE, next_step: STEP_IDLE};
    case (step)
      STEP_IDLE:     cw = '{OP_ACCEPT, CND_NO_WORK,    STEP_IDLE,   STEP_DISPATCH};
      STEP_DISPATCH: cw = '{OP_NOP,    CND_FULL,       STEP_LOAD,   STEP_PAD};
      STEP_LOAD:     cw = '{OP_LOAD,   CND_ALWAYS,     STEP_ROUND,  STEP_ROUND};
      STEP_ROUND:    cw = '{OP_ROUND,  CND_ROUND_MORE, STEP_ROUND,  STEP_ADD};
      STEP_ADD:      cw = '{OP_ADD,    CND_FINAL,      STEP_EMIT,   STEP_CHECK};
      STEP_CHECK:    cw = '{OP_NOP,    CND_LAST,       STEP_PAD,    STEP_IDLE};
      STEP_PAD:      cw = '{OP_PAD,    CND_ALWAYS,     STEP_ZERO,   STEP_ZERO};
      STEP_ZERO:     cw = '{OP_ZERO,   CND_ZERO_MORE,  STEP_ZERO,   STEP_WRAP};
      STEP_WRAP:     cw = '{OP_WRAP,   CND_WPTR_END,   STEP_LOAD,   STEP_LEN_LO};
      STEP_LEN_LO:   cw = '{OP_LEN_LO, CND_ALWAYS,     STEP_LEN_HI, STEP_LEN_HI};
      STEP_LEN_HI:   cw = '{OP_LEN_HI, CND_ALWAYS,     STEP_LOAD,   STEP_LOAD};
      STEP_EMIT:     cw = '{OP_EMIT,   CND_OUT_BUSY,   STEP_EMIT,   STEP_IDLE};
      default:       cw = '{OP_NOP,    CND_ALWAYS,     STEP_IDLE,   STEP_IDLE};
    endcase
    return cw;
  endfunction

  // Message word used by a given round.
  function automatic logic [BLOCK_ADDR_W-1:0] word_index(input logic [ROUND_W-1:0] rnd);
    logic [BLOCK_ADDR_W-1:0] low;
    logic [BLOCK_ADDR_W-1:0] idx;
    low = rnd[BLOCK_ADDR_W-1:0];
    case (rnd[ROUND_W-1:ROUND_W-2])
      2'd0:    idx = low;
      2'd1:    idx = BLOCK_ADDR_W'(low * 4'd5 + 4'd1);
      2'd2:    idx = BLOCK_ADDR_W'(low * 4'd3 + 4'd5);
      default: idx = BLOCK_ADDR_W'(low * 4'd7);
    endcase
    return idx;
  endfunction

  // Left rotation amount, by round group and position within four.
  function automatic logic [4:0] rot_amount(input logic [ROUND_W-1:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'd0:    s = 5'd7;
      4'd1:    s = 5'd12;
      4'd2:    s = 5'd17;
      4'd3:    s = 5'd22;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd9;
      4'd6:    s = 5'd14;
      4'd7:    s = 5'd20;
      4'd8:    s = 5'd4;
      4'd9:    s = 5'd11;
      4'd10:   s = 5'd16;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd6;
      4'd13:   s = 5'd10;
      4'd14:   s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Additive constant of each round.
  function automatic logic [WORD_W-1:0] round_add(input logic [ROUND_W-1:0] rnd);
    logic [WORD_W-1:0] k;
    case (rnd)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

[design/md5_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5 channel interfaces
// Valid/ready channels of the digest unit: the message byte stream in and
// the digest out.
// ----------------------------------------------------------------------------
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_present;
  logic       is_last;

  modport source (output valid, output msg_byte, output byte_present, output is_last,
                  input ready);
  modport sink   (input valid, input msg_byte, input byte_present, input is_last,
                  output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_low;
  logic [63:0] digest_high;

  modport source (output valid, output digest_low, output digest_high, input ready);
  modport sink   (input valid, input digest_low, input digest_high, output ready);
endinterface

[design/md5_message_digest_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_message_digest_unit
// MD5 digest of a byte stream, run by a small microcoded step sequencer.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one message byte per transaction, with a flag
// telling whether the byte is present and a flag that ends the message. A
// bare end marker (no byte, last set) closes a message, so an empty message
// is allowed. The output channel carries one transaction per message: the
// 128-bit digest in standard byte order, bytes 0 to 7 in digest_low.
// Throughput: plain bytes are taken at one per cycle, the next following at
// once. A byte that fills the 64-byte block holds the input while the
// compression runs, one round per cycle through the single round unit.
// An item that ends the message holds the input while the marker, the zero
// fill (one buffer word a cycle) and the length are written and the block is
// compressed, and through a second compression when its byte fills the
// block or 56 or more bytes sit in the last block.
// The digest sits in an output register; while it waits to be taken the
// unit goes on accepting bytes of the next message, and it only holds in
// its final step when a second digest is ready before the first is taken.
// Reset clears the chaining words to the initial values, the counters and
// the output valid; the block buffer needs no clearing.
// ----------------------------------------------------------------------------
module md5_message_digest_unit (
  input  logic    clk_i,
  input  logic    rst_ni,
  md5_in_if.sink  in_ch_i,
  md5_out_if.source out_ch_o
);
  import md5_pkg::*;

  // Sequencer and control flags.
  step_t                   pc_q, pc_d;
  ctrl_word_t              cw;
  logic                    cond_true;
  logic [ROUND_W-1:0]      round_q, round_d;
  logic [BYTE_CNT_W-1:0]   cnt_q, cnt_d;
  logic [MSG_BITS_W-1:0]   bits_q, bits_d;
  logic [WPTR_W-1:0]       wptr_q, wptr_d;
  logic                    full_q, full_d;
  logic                    last_q, last_d;
  logic                    pad_q, pad_d;
  logic                    ovf_q, ovf_d;
  logic                    len_done_q, len_done_d;
  logic                    out_valid_q, out_valid_d;

  // Datapath registers.
  md5_state_t              chain_q, chain_d;
  md5_state_t              work_q, work_d;
  md5_state_t              round_next;
  logic [WORD_W-1:0]       wbuf_q, wbuf_d;
  logic [WORD_W-1:0]       pad_word;
  logic [63:0]             dig_lo_q, dig_lo_d;
  logic [63:0]             dig_hi_q, dig_hi_d;

  // Block buffer port.
  logic                    ram_we;
  logic [BLOCK_ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0]       ram_wdata;
  logic [BLOCK_ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0]       ram_rdata;

  logic                    in_fire;
  logic                    no_work;
  logic                    zero_more;
  logic                    out_busy;
  logic [1:0]              lane;

  assign cw        = ucode_rom(pc_q);
  assign in_fire   = in_ch_i.valid && in_ch_i.ready;
  assign lane      = cnt_q[1:0];
  assign out_busy  = out_valid_q && !out_ch_o.ready;
  assign zero_more = !(wptr_q == WPTR_FILL && !ovf_q) && (wptr_q != WPTR_WRAP);
  assign no_work   = !(in_fire && (in_ch_i.is_last ||
                                   (in_ch_i.byte_present && cnt_q == BYTE_LAST)));

  assign in_ch_i.ready        = (cw.op == OP_ACCEPT);
  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.digest_low  = dig_lo_q;
  assign out_ch_o.digest_high = dig_hi_q;

  // Buffer word carrying the collected bytes, the 0x80 marker and zeros.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < lane) begin
        pad_word[8*j +: 8] = wbuf_q[8*j +: 8];
      end else if (2'(j) == lane) begin
        pad_word[8*j +: 8] = PAD_BYTE;
      end else begin
        pad_word[8*j +: 8] = 8'h00;
      end
    end
  end

  md5_ram #(
    .Width (WORD_W),
    .Depth (BLOCK_WORDS)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  md5_round u_round (
    .state_i (work_q),
    .word_i  (ram_rdata),
    .round_i (round_q),
    .state_o (round_next)
  );

  // Jump condition of the current step.
  always_comb begin
    case (cw.cond)
      CND_ALWAYS:     cond_true = 1'b1;
      CND_NO_WORK:    cond_true = no_work;
      CND_FULL:       cond_true = full_q;
      CND_ROUND_MORE: cond_true = (round_q != ROUND_LAST);
      CND_FINAL:      cond_true = len_done_q;
      CND_LAST:       cond_true = last_q;
      CND_ZERO_MORE:  cond_true = zero_more;
      CND_WPTR_END:   cond_true = (wptr_q == WPTR_WRAP);
      CND_OUT_BUSY:   cond_true = out_busy;
      default:        cond_true = 1'b1;
    endcase
  end

  assign pc_d = cond_true ? cw.jump_step : cw.next_step;

  // Datapath operation of the current step.
  always_comb begin
    round_d     = round_q;
    cnt_d       = cnt_q;
    bits_d      = bits_q;
    wptr_d      = wptr_q;
    full_d      = full_q;
    last_d      = last_q;
    pad_d       = pad_q;
    ovf_d       = ovf_q;
    len_done_d  = len_done_q;
    chain_d     = chain_q;
    work_d      = work_q;
    wbuf_d      = wbuf_q;
    dig_lo_d    = dig_lo_q;
    dig_hi_d    = dig_hi_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[BYTE_CNT_W-1:2];
    ram_wdata   = '0;
    ram_raddr   = word_index(ROUND_W'(round_q + ROUND_W'(1)));

    if (out_valid_q && out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (cw.op)
      OP_ACCEPT: begin
        if (in_fire) begin
          last_d = in_ch_i.is_last;
          full_d = in_ch_i.byte_present && (cnt_q == BYTE_LAST);
          if (in_ch_i.byte_present) begin
            wbuf_d[{lane, 3'b000} +: 8] = in_ch_i.msg_byte;
            cnt_d  = BYTE_CNT_W'(cnt_q + BYTE_CNT_W'(1));
            bits_d = bits_q + MSG_BITS_W'(8);
            if (lane == 2'd3) begin
              ram_we    = 1'b1;
              ram_wdata = {in_ch_i.msg_byte, wbuf_q[23:0]};
            end
          end
        end
      end
      OP_LOAD: begin
        work_d    = chain_q;
        round_d   = '0;
        full_d    = 1'b0;
        ram_raddr = word_index('0);
      end
      OP_ROUND: begin
        work_d  = round_next;
        round_d = ROUND_W'(round_q + ROUND_W'(1));
      end
      OP_ADD: begin
        chain_d.a = chain_q.a + work_q.a;
        chain_d.b = chain_q.b + work_q.b;
        chain_d.c = chain_q.c + work_q.c;
        chain_d.d = chain_q.d + work_q.d;
      end
      OP_PAD: begin
        // The marker word goes in once; the second pass of a two-block
        // finish only runs the zero fill.
        if (!pad_q) begin
          ram_we    = 1'b1;
          ram_wdata = pad_word;
          wptr_d    = WPTR_W'({1'b0, cnt_q[BYTE_CNT_W-1:2]} + WPTR_W'(1));
          ovf_d     = &cnt_q[BYTE_CNT_W-1:3];
          pad_d     = 1'b1;
        end
      end
      OP_ZERO: begin
        if (zero_more) begin
          ram_we    = 1'b1;
          ram_waddr = wptr_q[BLOCK_ADDR_W-1:0];
          wptr_d    = WPTR_W'(wptr_q + WPTR_W'(1));
        end
      end
      OP_WRAP: begin
        if (wptr_q == WPTR_WRAP) begin
          wptr_d = '0;
          ovf_d  = 1'b0;
        end
      end
      OP_LEN_LO: begin
        ram_we    = 1'b1;
        ram_waddr = WORD_LEN_LO;
        ram_wdata = bits_q[WORD_W-1:0];
      end
      OP_LEN_HI: begin
        ram_we     = 1'b1;
        ram_waddr  = WORD_LEN_HI;
        ram_wdata  = bits_q[MSG_BITS_W-1:WORD_W];
        len_done_d = 1'b1;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          dig_lo_d    = {chain_q.b, chain_q.a};
          dig_hi_d    = {chain_q.d, chain_q.c};
          out_valid_d = 1'b1;
          chain_d     = IV_STATE;
          cnt_d       = '0;
          bits_d      = '0;
          last_d      = 1'b0;
          pad_d       = 1'b0;
          ovf_d       = 1'b0;
          len_done_d  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state and chaining words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_IDLE;
      round_q     <= '0;
      cnt_q       <= '0;
      bits_q      <= '0;
      wptr_q      <= '0;
      full_q      <= 1'b0;
      last_q      <= 1'b0;
      pad_q       <= 1'b0;
      ovf_q       <= 1'b0;
      len_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
      chain_q     <= IV_STATE;
    end else begin
      pc_q        <= pc_d;
      round_q     <= round_d;
      cnt_q       <= cnt_d;
      bits_q      <= bits_d;
      wptr_q      <= wptr_d;
      full_q      <= full_d;
      last_q      <= last_d;
      pad_q       <= pad_d;
      ovf_q       <= ovf_d;
      len_done_q  <= len_done_d;
      out_valid_q <= out_valid_d;
      chain_q     <= chain_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    work_q   <= work_d;
    wbuf_q   <= wbuf_d;
    dig_lo_q <= dig_lo_d;
    dig_hi_q <= dig_hi_d;
  end

  // A new digest only appears from the final step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pc_q) == STEP_EMIT)
    else $error("digest valid raised outside the final step");

  // The round counter rests at zero outside the round loop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q != STEP_ROUND |-> round_q == '0)
    else $error("round counter not at zero outside the round loop");

  // The length block is only built after the message end and the marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_done_q |-> last_q && pad_q)
    else $error("length written without end of message and marker");

  // The final step is only reached once the length block is compressed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == STEP_EMIT |-> len_done_q && !ovf_q)
    else $error("final step reached before the last block");

  // The fill pointer never runs past one block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wptr_q <= WPTR_WRAP)
    else $error("fill pointer beyond the block");

endmodule

[design/md5_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module md5_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/md5_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_round
// One MD5 compression round: boolean function, additions, rotation and the
// rotation of the four working words.
// ----------------------------------------------------------------------------
module md5_round (
  input  md5_pkg::md5_state_t            state_i,
  input  logic [md5_pkg::WORD_W-1:0]     word_i,
  input  logic [md5_pkg::ROUND_W-1:0]    round_i,
  output md5_pkg::md5_state_t            state_o
);
  import md5_pkg::*;

  logic [WORD_W-1:0]   fn;
  logic [WORD_W-1:0]   sum;
  logic [2*WORD_W-1:0] dbl;
  logic [4:0]          shamt;

  // Boolean function of the round group.
  always_comb begin
    case (round_i[ROUND_W-1:ROUND_W-2])
      2'd0:    fn = (state_i.b & state_i.c) | (~state_i.b & state_i.d);
      2'd1:    fn = (state_i.b & state_i.d) | (state_i.c & ~state_i.d);
      2'd2:    fn = state_i.b ^ state_i.c ^ state_i.d;
      default: fn = state_i.c ^ (state_i.b | ~state_i.d);
    endcase
  end

  // Sum, left rotation via a doubled word, and the word shuffle.
  assign shamt = rot_amount(round_i);
  assign sum   = state_i.a + fn + round_add(round_i) + word_i;
  assign dbl   = {sum, sum} << shamt;

  assign state_o.a = state_i.d;
  assign state_o.b = state_i.b + dbl[2*WORD_W-1:WORD_W];
  assign state_o.c = state_i.b;
  assign state_o.d = state_i.c;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MD5 digest unit. A queue of byte transactions,
// filled up front, feeds a clocked driver; a clocked monitor compares every
// digest with the one predicted by a behavioural MD5 written in this file.
// Both channels idle at random, and the digest side holds off for a long
// stretch once so that the unit fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CLK_HALF    = 5;
  localparam int unsigned RESET_LEN   = 6;
  localparam int unsigned IDLE_PCT    = 6;
  localparam int unsigned QUIET_START = 4000;
  localparam int unsigned QUIET_END   = 9000;
  localparam int unsigned HOLD_START  = 1500;
  localparam int unsigned HOLD_LEN    = 800;
  localparam int unsigned DRAIN_WAIT  = 200;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MIN_BYTES   = 900;
  localparam int unsigned MIN_MSGS    = 16;

  // Additive constants of the 64 rounds.
  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotation amounts, four per round group.
  localparam int unsigned ROT_SHIFT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       is_last;
  } byte_item_t;

  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
  } digest_t;

  logic clk_i;
  logic rst_ni;

  md5_in_if  in_ch ();
  md5_out_if out_ch ();

  md5_message_digest_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  // Pending byte transactions and predicted digests.
  byte_item_t byte_q [$];
  digest_t    digest_q [$];

  // Predictor state: chaining words, block buffer, fill and bit length.
  logic [31:0] hash_words [4];
  logic [7:0]  blk_buf [64];
  logic [5:0]  blk_fill;
  logic [63:0] bit_count;

  int unsigned cycle_cnt;
  int unsigned hold_left;
  int unsigned fail_count;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // Random idling outside the quiet stretch.
  function automatic logic idle_now();
    if (cycle_cnt >= QUIET_START && cycle_cnt < QUIET_END) begin
      return 1'b0;
    end
    return $urandom_range(99, 0) < IDLE_PCT;
  endfunction

  task automatic restart_digest();
    hash_words[0] = 32'h67452301;
    hash_words[1] = 32'hefcdab89;
    hash_words[2] = 32'h98badcfe;
    hash_words[3] = 32'h10325476;
    blk_fill      = '0;
    bit_count     = '0;
  endtask

  // One MD5 compression of the block buffer into the chaining words.
  task automatic fold_block();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int unsigned i, g;
    for (i = 0; i < 16; i++) begin
      m[i] = {blk_buf[4*i+3], blk_buf[4*i+2], blk_buf[4*i+1], blk_buf[4*i]};
    end
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    for (i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = a + f + SINE_K[i] + m[g];
      a = d;
      d = c;
      c = b;
      b = b + rol32(t, ROT_SHIFT[(i / 16) * 4 + (i % 4)]);
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
  endtask

  // Absorbs one accepted transaction; a last item pads, finishes and
  // queues the predicted digest.
  task automatic md5_absorb(input logic [7:0] b, input logic present, input logic last);
    int unsigned i;
    digest_t dg;
    if (present) begin
      blk_buf[blk_fill] = b;
      bit_count += 64'd8;
      blk_fill += 6'd1;
      if (blk_fill == '0) begin
        fold_block();
      end
    end
    if (last) begin
      blk_buf[blk_fill] = 8'h80;
      for (i = blk_fill + 1; i < 64; i++) begin
        blk_buf[i] = 8'h00;
      end
      // Too little room for the length: spill into a second block.
      if (blk_fill >= 6'd56) begin
        fold_block();
        for (i = 0; i < 56; i++) begin
          blk_buf[i] = 8'h00;
        end
      end
      for (i = 0; i < 8; i++) begin
        blk_buf[56 + i] = bit_count[8*i +: 8];
      end
      fold_block();
      dg.low  = {hash_words[1], hash_words[0]};
      dg.high = {hash_words[3], hash_words[2]};
      digest_q.push_back(dg);
      restart_digest();
    end
  endtask

  task automatic add_item(input logic [7:0] b, input logic present, input logic last);
    byte_item_t it;
    it.msg_byte     = b;
    it.byte_present = present;
    it.is_last      = last;
    byte_q.push_back(it);
  endtask

  // A whole message with random bytes and occasional no-byte items mixed in;
  // it ends either on its final byte or with a bare end marker.
  task automatic add_message(input int unsigned len);
    int unsigned k;
    logic bare_end;
    bare_end = (len == 0) || ($urandom_range(1, 0) == 1);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(99, 0) < 5) begin
        add_item(8'($urandom), 1'b0, 1'b0);
      end
      add_item(8'($urandom), 1'b1, !bare_end && (k == len - 1));
    end
    if (bare_end) begin
      add_item(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // Cycle count and timeout.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items and %0d digests outstanding",
               $time, byte_q.size(), digest_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Long hold-off of the digest side, so that the unit fills up.
  always @(posedge clk_i) begin
    if (cycle_cnt == HOLD_START) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Driver: offers the head of the queue and predicts each transaction
  // as it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        md5_absorb(in_ch.msg_byte, in_ch.byte_present, in_ch.is_last);
        void'(byte_q.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_q.size() != 0 && !idle_now()) begin
          in_ch.valid        <= 1'b1;
          in_ch.msg_byte     <= byte_q[0].msg_byte;
          in_ch.byte_present <= byte_q[0].byte_present;
          in_ch.is_last      <= byte_q[0].is_last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each digest transaction against the oldest prediction.
  always @(posedge clk_i) begin
    digest_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest, expected none, actual %h %h",
                   $time, out_ch.digest_high, out_ch.digest_low);
          fail_count++;
        end else begin
          want = digest_q.pop_front();
          if (out_ch.digest_low !== want.low) begin
            $display("%0t: digest_low mismatch, expected %h, actual %h",
                     $time, want.low, out_ch.digest_low);
            fail_count++;
          end
          if (out_ch.digest_high !== want.high) begin
            $display("%0t: digest_high mismatch, expected %h, actual %h",
                     $time, want.high, out_ch.digest_high);
            fail_count++;
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && !idle_now();
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned n_bytes, n_msgs, len, r, k;
    rst_ni             = 1'b0;
    cycle_cnt          = 0;
    hold_left          = 0;
    fail_count         = 0;
    in_ch.valid        = 1'b0;
    in_ch.msg_byte     = '0;
    in_ch.byte_present = 1'b0;
    in_ch.is_last      = 1'b0;
    out_ch.ready       = 1'b0;
    restart_digest();

    // Directed: ignored item, empty message, byte extremes, a short text,
    // and a message closed by a bare end marker.
    add_item(8'hff, 1'b0, 1'b0);
    add_item(8'ha5, 1'b0, 1'b1);
    add_item(8'h00, 1'b1, 1'b1);
    add_item(8'hff, 1'b1, 1'b1);
    add_item(8'h61, 1'b1, 1'b0);
    add_item(8'h62, 1'b1, 1'b0);
    add_item(8'h63, 1'b1, 1'b1);
    add_item(8'h55, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b0);
    add_item(8'hff, 1'b0, 1'b1);
    add_item(8'haa, 1'b0, 1'b1);
    add_item(8'h7f, 1'b1, 1'b0);
    add_item(8'h80, 1'b1, 1'b1);

    // Random messages; the first few sit on the padding boundaries.
    n_bytes = 0;
    n_msgs  = 0;
    for (k = 0; k < 8; k++) begin
      case (k)
        0: len = 55;
        1: len = 56;
        2: len = 63;
        3: len = 64;
        4: len = 119;
        5: len = 120;
        6: len = 128;
        default: len = 0;
      endcase
      add_message(len);
      n_bytes += len;
      n_msgs++;
    end
    while (n_bytes < MIN_BYTES || n_msgs < MIN_MSGS) begin
      r = $urandom_range(99, 0);
      if (r < 45) begin
        len = $urandom_range(20, 0);
      end else if (r < 85) begin
        len = $urandom_range(70, 21);
      end else begin
        len = $urandom_range(140, 71);
      end
      add_message(len);
      n_bytes += len;
      n_msgs++;
    end

    repeat (RESET_LEN) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_q.size() != 0 || in_ch.valid) @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
